### rtl/lst_pkg.sv
// ---------------------------------------------------------------------------
// lst_pkg: shared types and codes of the token splitter
// Word types of the text and token channels, the core-to-queue push word,
// token kinds and error codes.
// ---------------------------------------------------------------------------
package lst_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    // Token kinds
    localparam logic [2:0] KIND_SYMBOL = 3'd0;
    localparam logic [2:0] KIND_BOOL   = 3'd1;
    localparam logic [2:0] KIND_INT    = 3'd2;
    localparam logic [2:0] KIND_FLOAT  = 3'd3;
    localparam logic [2:0] KIND_STRING = 3'd4;
    localparam logic [2:0] KIND_PUNCT  = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_POINT = 2'd1;
    localparam logic [1:0] ERR_QUOTE = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } lst_text_t;

    typedef struct packed {
        logic [7:0]             token_byte;
        logic [2:0]             token_kind;
        logic                   token_first;
        logic                   token_last;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [1:0]             error_code;
        logic                   step_last;
    } lst_token_t;

    // Up to two token words produced by one text word, packed to the front
    typedef struct packed {
        logic [1:0] cnt;
        lst_token_t res0;
        lst_token_t res1;
    } lst_push_t;

endpackage

### rtl/lst_core.sv
// ---------------------------------------------------------------------------
// lst_core: lexer state and per-word classification
// Classifies the held byte with the new byte as lookahead, and on end of
// text also flushes the new byte, giving up to two token words per word.
// ---------------------------------------------------------------------------
module lst_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  lst_pkg::lst_text_t item,
    input  logic              space_ok,
    output logic              take,
    output lst_pkg::lst_push_t push
);
    import lst_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_SYMBOL,
        M_INT,
        M_FRAC,
        M_STRING,
        M_COMMENT
    } mode_t;

    typedef struct packed {
        mode_t                  mode;
        logic [7:0]             held_byte;
        logic                   held_valid;
        logic [3:0]             bool_match;
        logic [LINE_BITS-1:0]   cur_line;
        logic [COLUMN_BITS-1:0] cur_col;
        logic [LINE_BITS-1:0]   tok_line;
        logic [COLUMN_BITS-1:0] tok_col;
        logic                   tok_float;
    } lex_state_t;

    typedef struct packed {
        lex_state_t st;
        logic       emit;
        lst_token_t res;
    } lex_step_t;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    // bool_match: 0 dead, 1..4 prefix of "true", 5..9 prefix of "false"
    localparam logic [3:0] BM_NONE  = 4'd0;
    localparam logic [3:0] BM_T     = 4'd1;
    localparam logic [3:0] BM_TRUE  = 4'd4;
    localparam logic [3:0] BM_F     = 4'd5;
    localparam logic [3:0] BM_FALSE = 4'd9;

    function automatic logic is_ws(logic [7:0] c);
        return c inside {8'h20, 8'h09, CH_LF, CH_CR};
    endfunction

    function automatic logic is_dig(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_brk(logic [7:0] c);
        return c inside {8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D};
    endfunction

    function automatic logic [3:0] bool_next(logic [3:0] bm, logic [7:0] c);
        logic [3:0] nb;
        nb = BM_NONE;
        case (bm)
            4'd1:    if (c == 8'h72) nb = 4'd2;  // r
            4'd2:    if (c == 8'h75) nb = 4'd3;  // u
            4'd3:    if (c == 8'h65) nb = 4'd4;  // e
            4'd5:    if (c == 8'h61) nb = 4'd6;  // a
            4'd6:    if (c == 8'h6C) nb = 4'd7;  // l
            4'd7:    if (c == 8'h73) nb = 4'd8;  // s
            4'd8:    if (c == 8'h65) nb = 4'd9;  // e
            default: nb = BM_NONE;
        endcase
        return nb;
    endfunction

    function automatic lex_state_t reset_state();
        lex_state_t s;
        s.mode       = M_IDLE;
        s.held_byte  = 8'h00;
        s.held_valid = 1'b0;
        s.bool_match = BM_NONE;
        s.cur_line   = LINE_ONE;
        s.cur_col    = COL_ONE;
        s.tok_line   = LINE_ONE;
        s.tok_col    = COL_ONE;
        s.tok_float  = 1'b0;
        return s;
    endfunction

    function automatic lst_token_t mk_tok(logic [7:0] c, logic [2:0] kind, logic first,
                                          logic last, logic [1:0] err, lex_state_t s);
        lst_token_t t;
        t.token_byte   = c;
        t.token_kind   = kind;
        t.token_first  = first;
        t.token_last   = last;
        t.start_line   = s.tok_line;
        t.start_column = s.tok_col;
        t.error_code   = err;
        t.step_last    = 1'b0;
        return t;
    endfunction

    // Classify one byte c with lookahead nx (has = lookahead present)
    function automatic lex_step_t lex_byte(lex_state_t s, logic [7:0] c, logic has,
                                           logic [7:0] nx);
        lex_step_t  r;
        logic       sym_end;
        logic [2:0] fk;
        r.st   = s;
        r.emit = 1'b0;
        r.res  = '0;
        sym_end = !has || is_ws(nx) || is_brk(nx);
        fk = s.tok_float ? KIND_FLOAT : KIND_INT;
        unique case (s.mode)
            M_IDLE:
            begin
                r.st.tok_line   = s.cur_line;
                r.st.tok_col    = s.cur_col;
                r.st.tok_float  = 1'b0;
                r.st.bool_match = BM_NONE;
                r.emit = 1'b1;
                if (is_ws(c)) begin
                    r.emit = 1'b0;
                end else if (c == CH_SEMI) begin
                    r.emit = 1'b0;
                    r.st.mode = M_COMMENT;
                end else if (c == CH_MINUS && has && (nx == CH_POINT || is_dig(nx))) begin
                    r.st.mode = M_INT;
                    r.res = mk_tok(c, KIND_INT, 1'b1, 1'b0, ERR_NONE, r.st);
                end else if (is_dig(c)) begin
                    if (has && (is_dig(nx) || nx == CH_POINT)) begin
                        r.st.mode = M_INT;
                        r.res = mk_tok(c, KIND_INT, 1'b1, 1'b0, ERR_NONE, r.st);
                    end else begin
                        r.res = mk_tok(c, KIND_INT, 1'b1, 1'b1, ERR_NONE, r.st);
                    end
                end else if (c == CH_POINT && has && is_dig(nx)) begin
                    r.st.mode      = M_FRAC;
                    r.st.tok_float = 1'b1;
                    r.res = mk_tok(c, KIND_FLOAT, 1'b1, 1'b0, ERR_NONE, r.st);
                end else if (c == CH_QUOTE) begin
                    if (!has) begin
                        r.res = mk_tok(c, KIND_STRING, 1'b1, 1'b1, ERR_QUOTE, r.st);
                    end else begin
                        r.st.mode = M_STRING;
                        r.res = mk_tok(c, KIND_STRING, 1'b1, 1'b0, ERR_NONE, r.st);
                    end
                end else if (is_brk(c)) begin
                    r.res = mk_tok(c, KIND_PUNCT, 1'b1, 1'b1, ERR_NONE, r.st);
                end else begin
                    r.st.bool_match = (c == 8'h74) ? BM_T : (c == 8'h66) ? BM_F : BM_NONE;
                    if (sym_end) begin
                        r.res = mk_tok(c, KIND_SYMBOL, 1'b1, 1'b1, ERR_NONE, r.st);
                    end else begin
                        r.st.mode = M_SYMBOL;
                        r.res = mk_tok(c, KIND_SYMBOL, 1'b1, 1'b0, ERR_NONE, r.st);
                    end
                end
            end
            M_SYMBOL:
            begin
                r.emit = 1'b1;
                r.st.bool_match = bool_next(s.bool_match, c);
                if (sym_end) begin
                    r.st.mode = M_IDLE;
                    r.res = mk_tok(c, (r.st.bool_match == BM_TRUE ||
                                       r.st.bool_match == BM_FALSE) ? KIND_BOOL : KIND_SYMBOL,
                                   1'b0, 1'b1, ERR_NONE, r.st);
                end else begin
                    r.res = mk_tok(c, KIND_SYMBOL, 1'b0, 1'b0, ERR_NONE, r.st);
                end
            end
            M_INT:
            begin
                r.emit = 1'b1;
                if (c == CH_POINT) begin
                    if (has && is_dig(nx)) begin
                        r.st.tok_float = 1'b1;
                        r.st.mode      = M_FRAC;
                        r.res = mk_tok(c, KIND_FLOAT, 1'b0, 1'b0, ERR_NONE, r.st);
                    end else begin
                        r.st.mode = M_IDLE;
                        r.res = mk_tok(c, KIND_INT, 1'b0, 1'b1, ERR_POINT, r.st);
                    end
                end else if (has && (is_dig(nx) || nx == CH_POINT)) begin
                    r.res = mk_tok(c, KIND_INT, 1'b0, 1'b0, ERR_NONE, r.st);
                end else begin
                    r.st.mode = M_IDLE;
                    r.res = mk_tok(c, KIND_INT, 1'b0, 1'b1, ERR_NONE, r.st);
                end
            end
            M_FRAC:
            begin
                r.emit = 1'b1;
                if (has && is_dig(nx)) begin
                    r.res = mk_tok(c, fk, 1'b0, 1'b0, ERR_NONE, r.st);
                end else begin
                    r.st.mode = M_IDLE;
                    r.res = mk_tok(c, fk, 1'b0, 1'b1, ERR_NONE, r.st);
                end
            end
            M_STRING:
            begin
                r.emit = 1'b1;
                if (c == CH_QUOTE) begin
                    r.st.mode = M_IDLE;
                    r.res = mk_tok(c, KIND_STRING, 1'b0, 1'b1, ERR_NONE, r.st);
                end else if (!has) begin
                    r.st.mode = M_IDLE;
                    r.res = mk_tok(c, KIND_STRING, 1'b0, 1'b1, ERR_QUOTE, r.st);
                end else begin
                    r.res = mk_tok(c, KIND_STRING, 1'b0, 1'b0, ERR_NONE, r.st);
                end
            end
            M_COMMENT:
            begin
                if (c == CH_LF || c == CH_CR) r.st.mode = M_IDLE;
            end
            default:
            begin
                r.st.mode = M_IDLE;
            end
        endcase
        // Advance the position; LF starts a new line, both counters saturate
        if (c == CH_LF) begin
            if (s.cur_line != LINE_MAX) r.st.cur_line = s.cur_line + LINE_ONE;
            r.st.cur_col = COL_ONE;
        end else if (s.cur_col != COL_MAX) begin
            r.st.cur_col = s.cur_col + COL_ONE;
        end
        return r;
    endfunction

    lex_state_t state_reg;
    lex_state_t state_next;
    lex_step_t  step_held;
    lex_step_t  step_flush;
    lst_token_t tok0;
    lst_token_t tok1;
    logic       v0;
    logic       v1;

    assign take = item_valid && space_ok;

    // Classify the held byte, then flush the new byte on end of text
    always_comb
    begin
        step_held = '{st: state_reg, emit: 1'b0, res: '0};
        if (state_reg.held_valid) begin
            step_held = lex_byte(state_reg, state_reg.held_byte, 1'b1, item.text_byte);
        end
        step_flush = lex_byte(step_held.st, item.text_byte, 1'b0, 8'h00);
        if (item.end_of_text) begin
            state_next = reset_state();
        end else begin
            state_next            = step_held.st;
            state_next.held_byte  = item.text_byte;
            state_next.held_valid = 1'b1;
        end
    end

    // Mark the last word of the step and pack the words to the front
    always_comb
    begin
        v0   = step_held.emit;
        v1   = item.end_of_text && step_flush.emit;
        tok0 = step_held.res;
        tok1 = step_flush.res;
        tok0.step_last = !v1;
        tok1.step_last = 1'b1;
        push.cnt  = 2'(v0) + 2'(v1);
        push.res0 = v0 ? tok0 : tok1;
        push.res1 = tok1;
        if (!take) push.cnt = 2'd0;
    end

    // Hold lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= reset_state();
        end else if (take) begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/lst_res_fifo.sv
// ---------------------------------------------------------------------------
// lst_res_fifo: token word queue
// Four-entry queue that takes up to two words a cycle from the core and
// hands one word a cycle to the token channel while token_ready is high.
// ---------------------------------------------------------------------------
module lst_res_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  lst_pkg::lst_push_t push,
    output logic               space_ok,
    output logic               token_valid,
    input  logic               token_ready,
    output lst_pkg::lst_token_t token
);
    import lst_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    lst_token_t          mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;
    logic [PTR_BITS-1:0] wr_ptr1;
    logic                pop;

    assign wr_ptr1     = wr_ptr_reg + PTR_BITS'(1);
    assign token_valid = (count_reg != '0);
    assign token       = mem[rd_ptr_reg];
    assign pop         = token_valid && token_ready;
    // Room for a full two-word push
    assign space_ok    = (count_reg <= (PTR_BITS+1)'(DEPTH - 2));

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0) mem[wr_ptr_reg] <= push.res0;
        if (push.cnt == 2'd2) mem[wr_ptr1]    <= push.res1;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(push.cnt);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            count_reg <= count_reg + (PTR_BITS+1)'(push.cnt) - (PTR_BITS+1)'(pop);
        end
    end

endmodule

### rtl/lisp_style_token_splitter.sv
// ---------------------------------------------------------------------------
// lisp_style_token_splitter: byte-stream lexer for Lisp-style text
// Splits a text byte stream into tokens and emits each token byte as one
// tagged word.
// ---------------------------------------------------------------------------
// Usage:
//   text channel: one source byte per word, end_of_text on the final byte.
//   token channel: one word per token byte with kind, first/last marks,
//   start line/column, error code and step_last on the last word caused by
//   a text word. Whitespace and comments produce no words.
// Order: a byte is classified once the following byte (its lookahead) is
//   taken. That text word waits in the input register; the byte's word
//   is written into the queue when the lexer takes that text word.
// Throughput: one text word per cycle while not stalled. An end_of_text word
//   may give two token words; the four-entry queue sends one per ready cycle.
// Reset: lexer returns between tokens at line 1, column 1, queue empty.
//   The same state is restored after every end-of-text word.
// Stall: while token_ready is low the queue fills; once fewer than two
//   entries are free the lexer stops and, while a word waits in the input
//   register, text_ready drops in the same cycle.
// ---------------------------------------------------------------------------
module lisp_style_token_splitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_ready,
    input  lst_pkg::lst_text_t  text,
    output logic                token_valid,
    input  logic                token_ready,
    output lst_pkg::lst_token_t token
);
    import lst_pkg::*;

    lst_text_t item_reg;
    logic      item_vld_reg;
    logic      space_ok;
    logic      take;
    lst_push_t push;

    assign text_ready = !item_vld_reg || take;

    // Input register: hold one text word until the lexer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_vld_reg <= 1'b0;
        end else if (text_ready) begin
            item_vld_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_ready && text_valid) item_reg <= text;
    end

    lst_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_vld_reg),
        .item       (item_reg),
        .space_ok   (space_ok),
        .take       (take),
        .push       (push)
    );

    lst_res_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .space_ok    (space_ok),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

endmodule

### verif/lisp_style_token_splitter_tb.sv
// ---------------------------------------------------------------------------
// lisp_style_token_splitter_tb: self-checking bench for the token splitter
// Drives text words through a valid/ready channel with bursty gaps, predicts
// every token word from its own lexer model, and checks the token channel
// under a changing stall pattern and one long hold-off.
// ---------------------------------------------------------------------------
package lst_tb_pkg;
    import lst_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_SYMBOL,
        LEX_INT,
        LEX_FRAC,
        LEX_STRING,
        LEX_COMMENT
    } lex_mode_e;

    // Bool word tracking: dead, or how far into "true" / "false" we are
    localparam int WORD_DEAD        = 0;
    localparam int WORD_TRUE_START  = 1;
    localparam int WORD_TRUE_DONE   = 4;
    localparam int WORD_FALSE_START = 5;
    localparam int WORD_FALSE_DONE  = 9;

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_bracket(logic [7:0] c);
        return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
    endfunction

    class token_scoreboard;
        lex_mode_e              mode;
        logic [7:0]             held_byte;
        bit                     held_ok;
        int                     word_state;
        logic [LINE_BITS-1:0]   cur_line;
        logic [LINE_BITS-1:0]   tok_line;
        logic [COLUMN_BITS-1:0] cur_col;
        logic [COLUMN_BITS-1:0] tok_col;
        bit                     frac_seen;
        lst_token_t             expected_tokens[$];
        int                     mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        // Return to the state of a fresh text
        function void clear();
            mode       = LEX_IDLE;
            held_byte  = 8'h00;
            held_ok    = 1'b0;
            word_state = WORD_DEAD;
            cur_line   = 1;
            cur_col    = 1;
            tok_line   = 1;
            tok_col    = 1;
            frac_seen  = 1'b0;
        endfunction

        function void add_token(logic [7:0] c, logic [2:0] kind, bit first, bit last,
                                logic [1:0] err);
            lst_token_t t;
            t.token_byte   = c;
            t.token_kind   = kind;
            t.token_first  = first;
            t.token_last   = last;
            t.start_line   = tok_line;
            t.start_column = tok_col;
            t.error_code   = err;
            t.step_last    = 1'b0;
            expected_tokens.insert(expected_tokens.size(), t);
        endfunction

        function int next_word_state(int ws, logic [7:0] c);
            string t_word = "true";
            string f_word = "false";
            if (ws >= WORD_TRUE_START && ws < WORD_TRUE_DONE &&
                c == t_word[ws - WORD_TRUE_START + 1])
                return ws + 1;
            if (ws >= WORD_FALSE_START && ws < WORD_FALSE_DONE &&
                c == f_word[ws - WORD_FALSE_START + 1])
                return ws + 1;
            return WORD_DEAD;
        endfunction

        // Classify one byte with its lookahead (has = lookahead present)
        function void lex_byte(logic [7:0] c, bit has, logic [7:0] nx);
            bit ends_sym;
            ends_sym = !has || is_space(nx) || is_bracket(nx);
            case (mode)
                LEX_IDLE:
                begin
                    tok_line   = cur_line;
                    tok_col    = cur_col;
                    frac_seen  = 1'b0;
                    word_state = WORD_DEAD;
                    if (is_space(c))
                    begin
                    end
                    else if (c == CH_SEMI)
                        mode = LEX_COMMENT;
                    else if (c == CH_MINUS && has && (nx == CH_POINT || is_digit(nx)))
                    begin
                        mode = LEX_INT;
                        add_token(c, KIND_INT, 1, 0, ERR_NONE);
                    end
                    else if (is_digit(c))
                    begin
                        if (has && (is_digit(nx) || nx == CH_POINT))
                        begin
                            mode = LEX_INT;
                            add_token(c, KIND_INT, 1, 0, ERR_NONE);
                        end
                        else
                            add_token(c, KIND_INT, 1, 1, ERR_NONE);
                    end
                    else if (c == CH_POINT && has && is_digit(nx))
                    begin
                        mode      = LEX_FRAC;
                        frac_seen = 1'b1;
                        add_token(c, KIND_FLOAT, 1, 0, ERR_NONE);
                    end
                    else if (c == CH_QUOTE)
                    begin
                        if (!has)
                            add_token(c, KIND_STRING, 1, 1, ERR_QUOTE);
                        else
                        begin
                            mode = LEX_STRING;
                            add_token(c, KIND_STRING, 1, 0, ERR_NONE);
                        end
                    end
                    else if (is_bracket(c))
                        add_token(c, KIND_PUNCT, 1, 1, ERR_NONE);
                    else
                    begin
                        word_state = (c == "t") ? WORD_TRUE_START :
                                     (c == "f") ? WORD_FALSE_START : WORD_DEAD;
                        if (ends_sym)
                            add_token(c, KIND_SYMBOL, 1, 1, ERR_NONE);
                        else
                        begin
                            mode = LEX_SYMBOL;
                            add_token(c, KIND_SYMBOL, 1, 0, ERR_NONE);
                        end
                    end
                end
                LEX_SYMBOL:
                begin
                    word_state = next_word_state(word_state, c);
                    if (ends_sym)
                    begin
                        add_token(c, (word_state == WORD_TRUE_DONE ||
                                      word_state == WORD_FALSE_DONE) ? KIND_BOOL : KIND_SYMBOL,
                                  0, 1, ERR_NONE);
                        mode = LEX_IDLE;
                    end
                    else
                        add_token(c, KIND_SYMBOL, 0, 0, ERR_NONE);
                end
                LEX_INT:
                begin
                    if (c == CH_POINT)
                    begin
                        if (has && is_digit(nx))
                        begin
                            frac_seen = 1'b1;
                            mode      = LEX_FRAC;
                            add_token(c, KIND_FLOAT, 0, 0, ERR_NONE);
                        end
                        else
                        begin
                            // bare point closes the number with an error
                            add_token(c, KIND_INT, 0, 1, ERR_POINT);
                            mode = LEX_IDLE;
                        end
                    end
                    else if (has && (is_digit(nx) || nx == CH_POINT))
                        add_token(c, KIND_INT, 0, 0, ERR_NONE);
                    else
                    begin
                        add_token(c, KIND_INT, 0, 1, ERR_NONE);
                        mode = LEX_IDLE;
                    end
                end
                LEX_FRAC:
                begin
                    if (has && is_digit(nx))
                        add_token(c, frac_seen ? KIND_FLOAT : KIND_INT, 0, 0, ERR_NONE);
                    else
                    begin
                        add_token(c, frac_seen ? KIND_FLOAT : KIND_INT, 0, 1, ERR_NONE);
                        mode = LEX_IDLE;
                    end
                end
                LEX_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        add_token(c, KIND_STRING, 0, 1, ERR_NONE);
                        mode = LEX_IDLE;
                    end
                    else if (!has)
                    begin
                        add_token(c, KIND_STRING, 0, 1, ERR_QUOTE);
                        mode = LEX_IDLE;
                    end
                    else
                        add_token(c, KIND_STRING, 0, 0, ERR_NONE);
                end
                default:
                begin
                    if (c == CH_LF || c == CH_CR)
                        mode = LEX_IDLE;
                end
            endcase
            // Advance the position, saturating
            if (c == CH_LF)
            begin
                if (cur_line != '1)
                    cur_line++;
                cur_col = 1;
            end
            else if (cur_col != '1)
                cur_col++;
        endfunction

        // Record an accepted text word and queue the token words it causes
        function void note_text(lst_text_t w);
            int         before_cnt;
            lst_token_t tail;
            before_cnt = expected_tokens.size();
            if (held_ok)
                lex_byte(held_byte, 1'b1, w.text_byte);
            if (w.end_of_text)
            begin
                lex_byte(w.text_byte, 1'b0, 8'h00);
                clear();
            end
            else
            begin
                held_byte = w.text_byte;
                held_ok   = 1'b1;
            end
            if (expected_tokens.size() > before_cnt)
            begin
                tail = expected_tokens.pop_back();
                tail.step_last = 1'b1;
                expected_tokens.insert(expected_tokens.size(), tail);
            end
        endfunction

        function string describe(lst_token_t t);
            return $sformatf("byte=%02h kind=%0d first=%0b last=%0b line=%0d col=%0d err=%0d sl=%0b",
                             t.token_byte, t.token_kind, t.token_first, t.token_last,
                             t.start_line, t.start_column, t.error_code, t.step_last);
        endfunction

        // Compare an accepted token word against the oldest prediction
        function void check_token(lst_token_t got);
            lst_token_t want;
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token word: %s", describe(got));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_byte   !== want.token_byte   ||
                got.token_kind   !== want.token_kind   ||
                got.token_first  !== want.token_first  ||
                got.token_last   !== want.token_last   ||
                got.start_line   !== want.start_line   ||
                got.start_column !== want.start_column ||
                got.error_code   !== want.error_code   ||
                got.step_last    !== want.step_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("token mismatch at %0t\n  expected %s\n  actual   %s",
                             $time, describe(want), describe(got));
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function bit failed();
            return mismatches != 0 || expected_tokens.size() != 0;
        endfunction
    endclass
endpackage

module lisp_style_token_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lst_pkg::*;
    import lst_tb_pkg::*;

    localparam int     RANDOM_WORDS   = 1500;
    localparam int     SQUEEZE_CYCLES = 400;
    localparam int     DRAIN_CYCLES   = 8;
    localparam longint CYCLE_LIMIT    = 4_000_000;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       text_valid  = 1'b0;
    logic       text_ready;
    lst_text_t  text        = '0;
    logic       token_valid;
    logic       token_ready = 1'b0;
    lst_token_t token;

    token_scoreboard sb;
    longint          cycle_count;
    bit              squeeze_req  = 1'b0;
    bit              squeeze_done = 1'b0;
    bit              steady       = 1'b0;
    int              burst_left   = 0;
    int              random_words = 0;
    logic [7:0]      src_bytes[$];

    lisp_style_token_splitter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text        (text),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog on total run length
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Token receiver: segments of different stall patterns, one long hold-off
    initial
    begin
        int seg_left;
        int pattern;
        int phase;
        seg_left = 0;
        pattern  = STALL_NONE;
        phase    = 0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                token_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                token_ready <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 150);
                    pattern  = $urandom_range(STALL_NONE, STALL_HEAVY);
                end
                seg_left--;
                phase++;
                case (pattern)
                    STALL_NONE:     token_ready <= 1'b1;
                    STALL_RANDOM:   token_ready <= ($urandom_range(0, 1) == 1);
                    STALL_PERIODIC: token_ready <= (phase % 3 == 0);
                    default:        token_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Check every accepted token word
    always @(posedge clk)
    begin
        if (rst_n && token_valid && token_ready)
            sb.check_token(token);
    end

    // Offer one text word, with bursty gaps unless the sender is steady
    task automatic send_word(logic [7:0] b, bit last);
        lst_text_t w;
        int        gap;
        w.text_byte   = b;
        w.end_of_text = last;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                text_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        text_valid <= 1'b1;
        text       <= w;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        sb.note_text(w);
    endtask

    task automatic send_string(string s, bit end_last);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], end_last && i == s.len() - 1);
    endtask

    // Send the built text, end flag on its final byte
    task automatic send_src();
        for (int i = 0; i < src_bytes.size(); i++)
            send_word(src_bytes[i], i == src_bytes.size() - 1);
        random_words += src_bytes.size();
        src_bytes.delete();
    endtask

    // Append one byte to the text under construction
    function automatic void add_byte(logic [7:0] b);
        src_bytes.insert(src_bytes.size(), b);
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] symbol_char(bit lead);
        string lead_set = "abcdefghijklmnopqrstuvwxyz+*?!<>=_tf:-.";
        string body_set = "abcdeftrulsxyz0123456789:;\"-.+*?!";
        if (lead)
            return lead_set[$urandom_range(0, lead_set.len() - 1)];
        return body_set[$urandom_range(0, body_set.len() - 1)];
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic void add_symbol();
        string w;
        int    n;
        case ($urandom_range(0, 5))
            0: w = "true";
            1: w = "false";
            2:
            begin
                w = ($urandom_range(0, 1) == 1) ? "true" : "false";
                w = w.substr(0, $urandom_range(0, w.len() - 2));
            end
            3: w = ($urandom_range(0, 1) == 1) ? "truex" : "falsey";
            default: w = "";
        endcase
        if (w.len() != 0)
            push_str(w);
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_byte(symbol_char(i == 0));
        end
    endfunction

    // Optional minus, digits, then nothing, a fraction, a bare point or point-letter
    function automatic void add_number();
        int n;
        if ($urandom_range(0, 2) == 0)
            add_byte(CH_MINUS);
        n = $urandom_range(0, 4);
        repeat (n) add_byte(digit_char());
        case ($urandom_range(0, 3))
            0:
            begin
                if (n == 0)
                    add_byte(digit_char());
            end
            1:
            begin
                add_byte(CH_POINT);
                repeat ($urandom_range(1, 3)) add_byte(digit_char());
            end
            2: add_byte(CH_POINT);
            default:
            begin
                add_byte(CH_POINT);
                add_byte(8'h61 + 8'($urandom_range(0, 25)));
            end
        endcase
    endfunction

    // Quoted string, sometimes left open
    function automatic void add_string();
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 3) == 0)
                add_byte(8'($urandom_range(0, 255)));
            else
                add_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        if ($urandom_range(0, 7) != 0)
            add_byte(CH_QUOTE);
    endfunction

    function automatic void add_comment();
        add_byte(CH_SEMI);
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
        case ($urandom_range(0, 2))
            0: add_byte(CH_LF);
            1: add_byte(CH_CR);
            default:
            begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        endcase
    endfunction

    function automatic void add_blank();
        repeat ($urandom_range(1, 3))
        begin
            case ($urandom_range(0, 4))
                0: add_byte(CH_TAB);
                1: add_byte(CH_LF);
                2: add_byte(CH_CR);
                3:
                begin
                    add_byte(CH_CR);
                    add_byte(CH_LF);
                end
                default: add_byte(CH_SPACE);
            endcase
        end
    endfunction

    function automatic void add_bracket();
        string br = "()[]{}";
        add_byte(br[$urandom_range(0, 5)]);
    endfunction

    // Build one text of mostly well-formed tokens with some noise
    function automatic void build_text();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: add_symbol();
                5, 6, 7, 8:    add_number();
                9, 10:         add_string();
                11, 12:        add_bracket();
                13:            add_comment();
                14:            add_byte(8'($urandom_range(0, 255)));
                default:       add_blank();
            endcase
            case ($urandom_range(0, 9))
                0: add_bracket();
                1: ;
                default: add_blank();
            endcase
        end
    endfunction

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bracket, bool, minus-point float, bare point, comment with
        // CR LF, minus symbol, lone quote at end, open string, byte extremes
        send_string("{true -.5 1.;c", 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b0);
        send_string("-a \"", 1'b1);
        send_string("\"x", 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);

        // Random texts; request the long receiver hold-off part way through
        while (random_words < RANDOM_WORDS)
        begin
            build_text();
            send_src();
            if (random_words > 300)
                squeeze_req = 1'b1;
        end

        // Back to back: CR LF counts as one line, then a fresh text
        steady = 1'b1;
        send_string("ab ", 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word("(", 1'b0);
        send_string("cd", 1'b1);
        // fresh text must start again at line 1, column 1
        send_string("7", 1'b1);
        steady = 1'b0;

        // Drain
        text_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failed())
            $display("Verification failed");
        else
            $display("Verification passed");
        $finish;
    end
endmodule

### sim.f
rtl/lst_pkg.sv
rtl/lst_core.sv
rtl/lst_res_fifo.sv
rtl/lisp_style_token_splitter.sv
verif/lisp_style_token_splitter_tb.sv
